// File: hw/rtl/glc_pkg.sv
// Shared constants, types and the color blend function of the glyph line compositor.
// Depends on nothing; every other file imports it.
package glc_pkg;

    localparam int MAX_WIDTH   = 720;
    localparam int MAX_HEIGHT  = 32;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int X_W         = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int EW_W        = $clog2(MAX_WIDTH + 1);
    localparam int EH_W        = $clog2(MAX_HEIGHT + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input actions
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_HEADER = 2'd1;
    localparam logic [1:0] ACT_PIXEL  = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_LINE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_FONT_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_BASELINE    = 3'd2;
    localparam logic [2:0] CFG_FORE_COLOR  = 3'd3;
    localparam logic [2:0] CFG_BACK_COLOR  = 3'd4;

    // Store operations passed from front to back
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        level;
    } t_op;

    function automatic logic [4:0] blend_chan(input logic [4:0] f, input logic [4:0] b,
                                              input logic [7:0] d);
        logic [7:0]  dn;
        logic [12:0] pf;
        logic [12:0] pb;
        logic [12:0] s;
        dn = 8'd255 - d;
        pf = 13'(f) * 13'(d);
        pb = 13'(b) * 13'(dn);
        s  = pf + pb;
        return s[12:8];
    endfunction

    function automatic logic [15:0] level_color(input logic [3:0] lv,
                                                input logic [15:0] fore,
                                                input logic [15:0] back);
        logic [7:0]  d;
        logic [15:0] c;
        d = {lv + 4'd1, 4'b0000};
        if (fore == back || lv == 4'd0) begin
            c = back;
        end else if (lv == 4'd15) begin
            c = fore;
        end else begin
            c = {1'b1,
                 blend_chan(fore[14:10], back[14:10], d),
                 blend_chan(fore[9:5], back[9:5], d),
                 blend_chan(fore[4:0], back[4:0], d)};
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/glyph_line_compositor.sv
// Top level of the glyph line compositor: configuration registers, busy logic
// and the front end, queue and back end. Uses glc_pkg.
//
// After reset the block sweeps the 23040-entry gray store to zero, one entry per
// cycle, with busy high for the whole sweep (configuration writes are taken
// throughout). An action is accepted when start is high and busy is low. Headers
// and clipped glyph pixels make no store access. A stored glyph pixel is a
// read-modify-write on the single store port: read on the pop, written in S_WR.
// A read is popped and passes S_RD; its color appears on o_pixel_color with
// o_valid high for one cycle, registered through the front register, queue,
// store read and color register. A clear action holds the back end for a whole
// store sweep. A four-entry queue lets the front keep accepting while the back
// end works; outside the reset sweep busy rises only when the queue fills.
// Results cannot be held off and must be taken the cycle o_valid is high.
module glyph_line_compositor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_advance_x,
    input  logic signed [15:0] i_advance_y,
    input  logic signed [7:0]  i_bearing_left,
    input  logic signed [7:0]  i_bearing_top,
    input  logic [7:0]         i_glyph_rows,
    input  logic [7:0]         i_glyph_cols,
    input  logic [7:0]         i_glyph_pixel,
    input  logic [9:0]         i_read_x,
    input  logic [4:0]         i_read_y,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [15:0]        o_pixel_color
);
    import glc_pkg::*;

    logic [9:0]  r_line_width;
    logic [5:0]  r_font_height;
    logic [4:0]  r_baseline;
    logic [15:0] r_fore_color;
    logic [15:0] r_back_color;

    logic [EW_W-1:0]   eff_w;
    logic [EH_W-1:0]   eff_h;
    logic              accept, push, pop, empty, init;
    t_op               op, head;
    logic [QCNT_W-1:0] cnt;
    logic [QCNT_W:0]   occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width  <= 10'd720;
            r_font_height <= 6'd22;
            r_baseline    <= 5'd17;
            r_fore_color  <= 16'hFFFF;
            r_back_color  <= 16'h8000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH:  r_line_width  <= i_cfg_data[9:0];
                CFG_FONT_HEIGHT: r_font_height <= i_cfg_data[5:0];
                CFG_BASELINE:    r_baseline    <= i_cfg_data[4:0];
                CFG_FORE_COLOR:  r_fore_color  <= i_cfg_data;
                CFG_BACK_COLOR:  r_back_color  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp the line size to the store
    assign eff_w = (16'(r_line_width) < 16'(MAX_WIDTH)) ? EW_W'(r_line_width)
                                                         : EW_W'(MAX_WIDTH);
    assign eff_h = (16'(r_font_height) < 16'(MAX_HEIGHT)) ? EH_W'(r_font_height)
                                                          : EH_W'(MAX_HEIGHT);

    // count the operation still in the front register against queue space
    assign occ    = {1'b0, cnt} + (QCNT_W + 1)'(push);
    assign busy   = init || (occ >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept = start && !busy;

    glc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_action       (i_action),
        .i_advance_x    (i_advance_x),
        .i_advance_y    (i_advance_y),
        .i_bearing_left (i_bearing_left),
        .i_bearing_top  (i_bearing_top),
        .i_glyph_rows   (i_glyph_rows),
        .i_glyph_cols   (i_glyph_cols),
        .i_glyph_pixel  (i_glyph_pixel),
        .i_read_x       (i_read_x),
        .i_read_y       (i_read_y),
        .i_eff_w        (eff_w),
        .i_eff_h        (eff_h),
        .i_baseline     (r_baseline),
        .o_push         (push),
        .o_op           (op)
    );

    glc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_cnt   (cnt)
    );

    glc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .i_fore  (r_fore_color),
        .i_back  (r_back_color),
        .o_init  (init),
        .o_valid (o_valid),
        .o_color (o_pixel_color)
    );

endmodule

// File: hw/rtl/glc_front.sv
// Front end: accepts actions, tracks pen and glyph raster position, clips pixels
// and turns store accesses into queued operations. Uses glc_pkg.
module glc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [1:0]               i_action,
    input  logic [15:0]              i_advance_x,
    input  logic signed [15:0]       i_advance_y,
    input  logic signed [7:0]        i_bearing_left,
    input  logic signed [7:0]        i_bearing_top,
    input  logic [7:0]               i_glyph_rows,
    input  logic [7:0]               i_glyph_cols,
    input  logic [7:0]               i_glyph_pixel,
    input  logic [9:0]               i_read_x,
    input  logic [4:0]               i_read_y,
    input  logic [glc_pkg::EW_W-1:0] i_eff_w,
    input  logic [glc_pkg::EH_W-1:0] i_eff_h,
    input  logic [4:0]               i_baseline,
    output logic                     o_push,
    output glc_pkg::t_op             o_op
);
    import glc_pkg::*;

    logic [15:0] r_pen_x, r_pen_y, r_org_x, r_org_y;
    logic        r_first;
    logic [7:0]  r_col, r_row, r_cur_cols, r_cur_rows;

    logic             r_s1_valid;
    logic [1:0]       r_s1_kind;
    logic             r_s1_hit;
    logic [X_W-1:0]   r_s1_x;
    logic [ROW_W-1:0] r_s1_y;
    logic [3:0]       r_s1_level;

    logic [15:0] bl16, bt16, pen_x_base, pen_y_base, ady_sh;
    logic        live, pix_hit, rd_hit, col_wrap;
    logic [16:0] pi, pj;
    logic [ADDR_W-1:0] addr_c;

    always_comb begin
        bl16       = {{8{i_bearing_left[7]}}, i_bearing_left};
        bt16       = {{8{i_bearing_top[7]}}, i_bearing_top};
        pen_x_base = r_first ? (16'd0 - bl16) : r_pen_x;
        pen_y_base = r_first ? 16'(i_baseline) : r_pen_y;
        // floor divide by 64
        ady_sh     = {{6{i_advance_y[15]}}, i_advance_y[15:6]};

        live     = (r_cur_cols != 8'd0) && (r_row < r_cur_rows);
        pi       = {r_org_x[15], r_org_x} + {9'd0, r_col};
        pj       = {r_org_y[15], r_org_y} + {9'd0, r_row};
        pix_hit  = !pi[16] && !pj[16] && (pi[15:0] < 16'(i_eff_w))
                   && (pj[15:0] < 16'(i_eff_h));
        col_wrap = ({1'b0, r_col} + 9'd1) >= {1'b0, r_cur_cols};
        rd_hit   = (16'(i_read_x) < 16'(i_eff_w)) && (16'(i_read_y) < 16'(i_eff_h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x    <= '0;
            r_pen_y    <= '0;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_first    <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
            r_cur_cols <= '0;
            r_cur_rows <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                case (i_action)
                    ACT_CLEAR: begin
                        r_first    <= 1'b1;
                        r_col      <= '0;
                        r_row      <= '0;
                        r_cur_cols <= '0;
                        r_cur_rows <= '0;
                        r_s1_valid <= 1'b1;
                    end
                    ACT_HEADER: begin
                        r_first    <= 1'b0;
                        r_org_x    <= pen_x_base + bl16;
                        r_org_y    <= pen_y_base - bt16;
                        r_cur_rows <= i_glyph_rows;
                        r_cur_cols <= i_glyph_cols;
                        r_col      <= '0;
                        r_row      <= '0;
                        r_pen_x    <= pen_x_base + {6'd0, i_advance_x[15:6]};
                        r_pen_y    <= pen_y_base + ady_sh;
                        r_s1_valid <= 1'b0;
                    end
                    ACT_PIXEL: begin
                        r_s1_valid <= live && pix_hit;
                        if (live) begin
                            if (col_wrap) begin
                                r_col <= '0;
                                r_row <= r_row + 8'd1;
                            end else begin
                                r_col <= r_col + 8'd1;
                            end
                        end
                    end
                    ACT_READ: begin
                        r_s1_valid <= 1'b1;
                    end
                    default: begin
                        r_s1_valid <= 1'b0;
                    end
                endcase
            end else begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Payload of the pending operation
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_level <= i_glyph_pixel[7:4];
            case (i_action)
                ACT_CLEAR: begin
                    r_s1_kind <= OP_CLEAR;
                    r_s1_hit  <= 1'b0;
                    r_s1_x    <= '0;
                    r_s1_y    <= '0;
                end
                ACT_PIXEL: begin
                    r_s1_kind <= OP_WRITE;
                    r_s1_hit  <= 1'b1;
                    r_s1_x    <= X_W'(pi[15:0]);
                    r_s1_y    <= ROW_W'(pj[15:0]);
                end
                ACT_READ: begin
                    r_s1_kind <= OP_READ;
                    r_s1_hit  <= rd_hit;
                    r_s1_x    <= rd_hit ? X_W'(i_read_x) : '0;
                    r_s1_y    <= rd_hit ? ROW_W'(i_read_y) : '0;
                end
                default: begin
                    r_s1_kind <= OP_CLEAR;
                    r_s1_hit  <= 1'b0;
                    r_s1_x    <= '0;
                    r_s1_y    <= '0;
                end
            endcase
        end
    end

    assign addr_c = ADDR_W'(r_s1_y) * ADDR_W'(i_eff_w) + ADDR_W'(r_s1_x);

    assign o_push = r_s1_valid;
    always_comb begin
        o_op.kind  = r_s1_kind;
        o_op.hit   = r_s1_hit;
        o_op.addr  = addr_c;
        o_op.level = r_s1_level;
    end

endmodule

// File: hw/rtl/glc_queue.sv
// Short operation queue between front and back end.
// Uses glc_pkg for the operation type and depth.
module glc_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  glc_pkg::t_op               i_op,
    input  logic                       i_pop,
    output glc_pkg::t_op               o_head,
    output logic                       o_empty,
    output logic [glc_pkg::QCNT_W-1:0] o_cnt
);
    import glc_pkg::*;

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head  = r_slot[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_cnt   = r_cnt;

endmodule

// File: hw/rtl/glc_back.sv
// Back end: owns the gray line store, runs clear sweeps, read-modify-write ORs
// and color readout through the level blend. Uses glc_pkg.
module glc_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  glc_pkg::t_op i_head,
    input  logic         i_empty,
    output logic         o_pop,
    input  logic [15:0]  i_fore,
    input  logic [15:0]  i_back,
    output logic         o_init,
    output logic         o_valid,
    output logic [15:0]  o_color
);
    import glc_pkg::*;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_WR   = 2'd2;
    localparam logic [1:0] S_RD   = 2'd3;

    logic [3:0] mem [STORE_DEPTH];

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_init, n_init;
    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [3:0]        r_level;
    logic              r_hit;
    logic [3:0]        r_rdata;
    logic [15:0]       r_color;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] wa;
    logic [3:0]        wd;

    always_comb begin
        o_pop      = (r_state == S_IDLE) && !i_empty;
        mem_re     = o_pop && ((i_head.kind == OP_WRITE)
                               || ((i_head.kind == OP_READ) && i_head.hit));
        mem_we     = (r_state == S_CLR) || (r_state == S_WR);
        wa         = (r_state == S_CLR) ? r_clr_addr : r_addr;
        wd         = (r_state == S_CLR) ? 4'd0 : (r_rdata | r_level);
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_init     = r_init;
        case (r_state)
            S_CLR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                    n_init  = 1'b0;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    case (i_head.kind)
                        OP_CLEAR: begin
                            n_state    = S_CLR;
                            n_clr_addr = '0;
                        end
                        OP_WRITE: n_state = S_WR;
                        OP_READ:  n_state = S_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_WR:    n_state = S_IDLE;
            S_RD:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wa] <= wd;
        end
        if (mem_re) begin
            r_rdata <= mem[i_head.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_init     <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_init     <= n_init;
            r_valid    <= (r_state == S_RD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr  <= i_head.addr;
            r_level <= i_head.level;
            r_hit   <= i_head.hit;
        end
        // a read outside the line takes level zero
        if (r_state == S_RD) begin
            r_color <= level_color(r_hit ? r_rdata : 4'd0, i_fore, i_back);
        end
    end

    assign o_init  = r_init;
    assign o_valid = r_valid;
    assign o_color = r_color;

endmodule

// File: dv/tb_glyph_line_compositor.sv
// Self-checking testbench for glyph_line_compositor: directed and random text lines.
// A scoreboard class keeps its own copy of the gray line store and predicts every read.
// Depends on glc_pkg and the glyph_line_compositor RTL.
module tb_glyph_line_compositor;
    timeunit 1ns;
    timeprecision 1ps;
    import glc_pkg::*;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        advance_x;
        logic signed [15:0] advance_y;
        logic signed [7:0]  bearing_left;
        logic signed [7:0]  bearing_top;
        logic [7:0]         glyph_rows;
        logic [7:0]         glyph_cols;
        logic [7:0]         glyph_pixel;
        logic [9:0]         read_x;
        logic [4:0]         read_y;
    } t_glyph_item;

    class line_composer;
        bit [3:0]  gray [STORE_DEPTH];
        bit [9:0]  width_reg  = 10'd720;
        bit [5:0]  height_reg = 6'd22;
        bit [4:0]  base_reg   = 5'd17;
        bit [15:0] fore_reg   = 16'hFFFF;
        bit [15:0] back_reg   = 16'h8000;
        bit [15:0] pen_x;
        bit [15:0] pen_y;
        bit [15:0] org_x;
        bit [15:0] org_y;
        bit        first_glyph = 1'b1;
        bit [7:0]  glyph_rows;
        bit [7:0]  glyph_cols;
        int        col_cnt;
        int        row_cnt;
        bit [15:0] colors_due [$];
        int        mismatches;

        function int line_w();
            return (width_reg < MAX_WIDTH) ? int'(width_reg) : MAX_WIDTH;
        endfunction

        function int line_h();
            return (height_reg < MAX_HEIGHT) ? int'(height_reg) : MAX_HEIGHT;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_LINE_WIDTH:  width_reg  = data[9:0];
                CFG_FONT_HEIGHT: height_reg = data[5:0];
                CFG_BASELINE:    base_reg   = data[4:0];
                CFG_FORE_COLOR:  fore_reg   = data;
                CFG_BACK_COLOR:  back_reg   = data;
                default: ;
            endcase
        endfunction

        // 16-step blend from background (level 0) to foreground (level 15)
        function bit [15:0] shade(bit [3:0] lv);
            int        d;
            bit [15:0] c;
            if (fore_reg == back_reg || lv == 4'd0) return back_reg;
            if (lv == 4'd15) return fore_reg;
            d = 16 * (int'(lv) + 1);
            c = 16'h8000;
            for (int k = 0; k < 3; k++) begin
                c[k*5 +: 5] = 5'((int'(fore_reg[k*5 +: 5]) * d
                                  + (255 - d) * int'(back_reg[k*5 +: 5])) >> 8);
            end
            return c;
        endfunction

        function void take_action(t_glyph_item it);
            bit [15:0] blx;
            bit [15:0] btx;
            int        xi;
            int        yi;
            bit [3:0]  lv;
            blx = {{8{it.bearing_left[7]}}, it.bearing_left};
            btx = {{8{it.bearing_top[7]}}, it.bearing_top};
            case (it.action)
                ACT_CLEAR: begin
                    foreach (gray[k]) gray[k] = 4'd0;
                    first_glyph = 1'b1;
                    glyph_rows = 8'd0;
                    glyph_cols = 8'd0;
                    row_cnt = 0;
                    col_cnt = 0;
                end
                ACT_HEADER: begin
                    if (first_glyph) begin
                        pen_x = 16'd0 - blx;
                        pen_y = 16'(base_reg);
                        first_glyph = 1'b0;
                    end
                    org_x = pen_x + blx;
                    org_y = pen_y - btx;
                    glyph_rows = it.glyph_rows;
                    glyph_cols = it.glyph_cols;
                    row_cnt = 0;
                    col_cnt = 0;
                    // 10.6 advances, floor toward minus infinity
                    pen_x = pen_x + {6'd0, it.advance_x[15:6]};
                    pen_y = pen_y + {{6{it.advance_y[15]}}, it.advance_y[15:6]};
                end
                ACT_PIXEL: begin
                    if (glyph_cols != 8'd0 && row_cnt < glyph_rows) begin
                        xi = int'($signed(org_x)) + col_cnt;
                        yi = int'($signed(org_y)) + row_cnt;
                        if (xi >= 0 && yi >= 0 && xi < line_w() && yi < line_h())
                            gray[yi * line_w() + xi] |= it.glyph_pixel[7:4];
                        col_cnt++;
                        if (col_cnt >= glyph_cols) begin
                            col_cnt = 0;
                            row_cnt++;
                        end
                    end
                end
                ACT_READ: begin
                    lv = 4'd0;
                    if (int'(it.read_x) < line_w() && int'(it.read_y) < line_h())
                        lv = gray[int'(it.read_y) * line_w() + int'(it.read_x)];
                    colors_due.push_back(shade(lv));
                end
                default: ;
            endcase
        endfunction

        function void match_color(logic [15:0] got);
            logic [15:0] want;
            if (colors_due.size() == 0) begin
                $error("pixel_color: no read pending, actual %h", got);
                mismatches++;
            end else begin
                want = colors_due.pop_front();
                if (got !== want) begin
                    $error("pixel_color: expected %h, actual %h", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = CFG_LINE_WIDTH;
    logic [15:0] i_cfg_data = 16'd0;
    logic        o_valid;
    logic [15:0] o_pixel_color;
    t_glyph_item cur        = '0;

    line_composer composer = new();
    int           burst_left;
    int           line_items;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    glyph_line_compositor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (cur.action),
        .i_advance_x    (cur.advance_x),
        .i_advance_y    (cur.advance_y),
        .i_bearing_left (cur.bearing_left),
        .i_bearing_top  (cur.bearing_top),
        .i_glyph_rows   (cur.glyph_rows),
        .i_glyph_cols   (cur.glyph_cols),
        .i_glyph_pixel  (cur.glyph_pixel),
        .i_read_x       (cur.read_x),
        .i_read_y       (cur.read_y),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_pixel_color  (o_pixel_color)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) composer.match_color(o_pixel_color);
            if (start && !busy) composer.take_action(cur);
        end
    end

    // fields that the action ignores still carry random values
    function automatic t_glyph_item scramble();
        t_glyph_item it;
        it.action       = 2'($urandom);
        it.advance_x    = 16'($urandom);
        it.advance_y    = 16'($urandom);
        it.bearing_left = 8'($urandom);
        it.bearing_top  = 8'($urandom);
        it.glyph_rows   = 8'($urandom);
        it.glyph_cols   = 8'($urandom);
        it.glyph_pixel  = 8'($urandom);
        it.read_x       = 10'($urandom);
        it.read_y       = 5'($urandom);
        return it;
    endfunction

    function automatic t_glyph_item clear_item();
        t_glyph_item it;
        it = scramble();
        it.action = ACT_CLEAR;
        return it;
    endfunction

    function automatic t_glyph_item header_item(int adx, int ady, int bl, int bt,
                                                int rows, int cols);
        t_glyph_item it;
        it = scramble();
        it.action       = ACT_HEADER;
        it.advance_x    = 16'(adx);
        it.advance_y    = 16'(ady);
        it.bearing_left = 8'(bl);
        it.bearing_top  = 8'(bt);
        it.glyph_rows   = 8'(rows);
        it.glyph_cols   = 8'(cols);
        return it;
    endfunction

    function automatic t_glyph_item pixel_item(int p);
        t_glyph_item it;
        it = scramble();
        it.action      = ACT_PIXEL;
        it.glyph_pixel = 8'(p);
        return it;
    endfunction

    function automatic t_glyph_item read_item(int x, int y);
        t_glyph_item it;
        it = scramble();
        it.action = ACT_READ;
        it.read_x = 10'(x);
        it.read_y = 5'(y);
        return it;
    endfunction

    // present one transaction and hold it until the block takes it
    task automatic send(t_glyph_item it, bit counted);
        cur = it;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
        if (counted) line_items++;
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = 16'(val);
        composer.set_reg(idx, 16'(val));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic settle();
        while (composer.colors_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // bursts of back-to-back transactions separated by short gaps
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(0, 20);
        end
    endtask

    task automatic read_burst(int n);
        int x;
        int y;
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                x = $urandom_range(0, 1023);
                y = $urandom_range(0, 31);
            end else begin
                x = $urandom_range(0, (composer.line_w() < 168 ? composer.line_w() : 168) + 3);
                y = $urandom_range(0, composer.line_h() < 31 ? composer.line_h() : 31);
            end
            send(read_item(x, y), 1'b1);
            pace();
        end
    endtask

    task automatic draw_glyph();
        int rows;
        int cols;
        int count;
        int adx;
        int ady;
        int bl;
        int bt;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            rows = $urandom_range(128, 255);
            cols = $urandom_range(1, 2);
        end else if (sel == 1) begin
            rows = $urandom_range(1, 2);
            cols = $urandom_range(128, 255);
        end else if (sel == 2) begin
            rows = $urandom_range(0, 255);
            cols = 0;
        end else begin
            rows = $urandom_range(0, 12);
            cols = $urandom_range(1, 12);
        end
        adx = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
            : ($urandom_range(0, cols + 2) << 6) | $urandom_range(0, 63);
        sel = $urandom_range(0, 9);
        ady = (sel == 0) ? $urandom_range(0, 65535)
            : (sel == 1) ? int'($urandom_range(0, 511)) - 256 : 0;
        bl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
            : int'($urandom_range(0, 6)) - 2;
        bt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 14);
        send(header_item(adx, ady, bl, bt, rows, cols), 1'b1);
        pace();
        if (cols == 0) begin
            // no columns: every pixel is dropped
            repeat ($urandom_range(1, 3)) begin
                send(pixel_item($urandom_range(0, 255)), 1'b0);
                pace();
            end
        end else begin
            count = rows * cols;
            if ($urandom_range(0, 5) == 0) count = $urandom_range(0, count);
            repeat (count) begin
                send(pixel_item($urandom_range(0, 255)), 1'b1);
                pace();
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send(pixel_item($urandom_range(0, 255)), 1'b0);
                    pace();
                end
            end
        end
    endtask

    task automatic compose_line(int budget);
        int pick;
        line_items = 0;
        send(clear_item(), 1'b1);
        pace();
        while (line_items < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                draw_glyph();
            end else if (pick < 80) begin
                read_burst($urandom_range(1, 8));
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 3)) begin
                    send(pixel_item($urandom_range(0, 255)), 1'b0);
                    pace();
                end
            end else if (pick < 95) begin
                send(header_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255), $urandom_range(0, 255)), 1'b1);
                pace();
            end else begin
                // hold off until every pending read has returned
                settle();
            end
        end
        read_burst(16);
    endtask

    initial begin
        int widths  [8] = '{64, 2, 720, 1023, 0, 1, 100, 40};
        int heights [8] = '{16, 1, 32, 63, 8, 4, 24, 12};
        int bases   [8] = '{12, 0, 31, 20, 5, 3, 18, 9};
        int fores   [8] = '{-1, 'h7FFF, 'hFFFF, -1, -1, -1, 'h0000, -1};
        int backs   [8] = '{-1, 'h0000, 'h8000, -2, -1, -1, 'hFFFF, -1};
        int pix     [6] = '{'hFF, 'h10, 'h80, 'h0F, 'hF0, 'h7F};
        int fore;
        int back;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send(read_item(0, 0), 1'b1);
        // first glyph: pen starts at minus the left bearing, so the bitmap lands at column 0
        send(header_item('h023F, 0, -1, 3, 2, 3), 1'b1);
        foreach (pix[k]) send(pixel_item(pix[k]), 1'b1);
        send(pixel_item('hFF), 1'b1);
        for (int y = 14; y < 16; y++) begin
            for (int x = 0; x < 3; x++) send(read_item(x, y), 1'b1);
        end
        send(header_item('hFFFF, -32768, 127, -128, 255, 0), 1'b1);
        send(pixel_item('hAA), 1'b1);
        send(header_item(0, 32767, -128, 127, 2, 2), 1'b1);
        send(pixel_item('hFF), 1'b1);
        // a new header abandons the rest of the previous glyph
        send(header_item('h40, 0, 0, 0, 1, 1), 1'b1);
        send(read_item(1023, 31), 1'b1);
        send(read_item(719, 21), 1'b1);
        send(clear_item(), 1'b1);
        send(read_item(0, 14), 1'b1);
        send(header_item(0, 0, 5, 1, 1, 1), 1'b1);
        send(pixel_item('hF0), 1'b1);
        send(read_item(0, 16), 1'b1);
        settle();

        for (int p = 0; p < 8; p++) begin
            fore = (fores[p] < 0) ? $urandom_range(0, 65535) : fores[p];
            back = (backs[p] == -2) ? fore
                 : (backs[p] < 0) ? $urandom_range(0, 65535) : backs[p];
            write_reg(CFG_LINE_WIDTH, widths[p]);
            write_reg(CFG_FONT_HEIGHT, heights[p]);
            write_reg(CFG_BASELINE, bases[p]);
            write_reg(CFG_FORE_COLOR, fore);
            write_reg(CFG_BACK_COLOR, back);
            compose_line(128);
            settle();
        end

        repeat (16) @(posedge i_clk);
        if (composer.mismatches == 0 && composer.colors_due.size() == 0) begin
            $display("tb_glyph_line_compositor: clean");
        end else begin
            $display("tb_glyph_line_compositor: errors");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb_glyph_line_compositor: errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/glc_pkg.sv
hw/rtl/glc_front.sv
hw/rtl/glc_queue.sv
hw/rtl/glc_back.sv
hw/rtl/glyph_line_compositor.sv
dv/tb_glyph_line_compositor.sv
